>>> hw/rtl/lsfa_pkg.sv
// Package: shared state codes and the control struct for the seat allocator.
`default_nettype none
package lsfa_pkg;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_EVENT,
      ST_DEP_RD,
      ST_DEP_WR,
      ST_DEP_RD2,
      ST_DEP_WR2,
      ST_ARR_RD,
      ST_ARR_CHK,
      ST_ARR_RD2,
      ST_ARR_WR2,
      ST_NEXT,
      ST_RPT_RD,
      ST_RPT_OUT
   } state_type;

   // Control from the sequencer to the next-event selector.
   typedef struct packed {
      logic restart;     // new set: forget the last processed event
      logic scan_start;  // new scan: forget the running minimum
      logic sample;      // read data of one occupant is valid
      logic commit;      // the running minimum becomes the last processed event
   } sel_ctrl_type;

endpackage
`default_nettype wire

>>> hw/rtl/lsfa_ram.sv
// Module: single-port-write, single-port-read synchronous RAM with registered read.
`default_nettype none
module lsfa_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> hw/rtl/lsfa_next_event.sv
// Module: running-minimum selector that finds the next event key above the last one.
`default_nettype none
module lsfa_next_event #(
   parameter int TIME_BITS = 16,
   parameter int IDX_BITS  = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lsfa_pkg::sel_ctrl_type        ctrl,
   input  wire logic [TIME_BITS-1:0]          arr_time,
   input  wire logic [TIME_BITS-1:0]          dep_time,
   input  wire logic [IDX_BITS-1:0]           idx,
   output logic [TIME_BITS+IDX_BITS:0]        best_key,
   output logic                               best_found
);

   localparam int KW = TIME_BITS + 1 + IDX_BITS;

   logic [KW-1:0] prev_ff, prev_in;
   logic          have_prev_ff, have_prev_in;
   logic [KW-1:0] best_ff, best_in;
   logic          best_valid_ff, best_valid_in;

   logic [KW-1:0] key_a, key_d, pair_key;
   logic          ok_a, ok_d, pair_ok;

   // Build both keys: time, then kind (departure first), then index
   assign key_a = {arr_time, 1'b1, idx};
   assign key_d = {dep_time, 1'b0, idx};

   // Pick the smaller eligible key of this occupant
   always_comb begin
      ok_a = !have_prev_ff || (key_a > prev_ff);
      ok_d = !have_prev_ff || (key_d > prev_ff);
      pair_ok = ok_a || ok_d;
      if (ok_a && ok_d) begin
         pair_key = (key_a < key_d) ? key_a : key_d;
      end else if (ok_a) begin
         pair_key = key_a;
      end else begin
         pair_key = key_d;
      end
   end

   // Fold into the running minimum, advance the last processed key
   always_comb begin
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      if (ctrl.commit) begin
         prev_in      = best_ff;
         have_prev_in = 1'b1;
      end
      if (ctrl.restart) begin
         have_prev_in = 1'b0;
      end
      if (ctrl.scan_start) begin
         best_valid_in = 1'b0;
      end else if (ctrl.sample && pair_ok && (!best_valid_ff || pair_key < best_ff)) begin
         best_in       = pair_key;
         best_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         have_prev_ff  <= have_prev_in;
         best_valid_ff <= best_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      best_ff <= best_in;
   end

   assign best_key   = best_ff;
   assign best_found = best_valid_ff;

endmodule
`default_nettype wire

>>> hw/rtl/lowest_free_seat_allocator_top.sv
// Top level: occupant loading, event sequencing and lowest-free seat allocation.
//
//  Channel   Ports                                   Handshake
//  request   start, busy, req_arrival_time,          taken when start & !busy
//            req_leaving_time, req_last_occupant
//  response  rsp_valid, rsp_seat, rsp_target_missing one-cycle strobe, no stall
//  config    csr_wr_en, csr_wr_data                  written when csr_wr_en
//
// Loading accepts one transaction per cycle. The transaction marked last starts
// allocation: a clearing pass over the state memory, then for each of the 2N
// events a scan of the time memory plus a read-modify-write of the state
// memory (its read repeated for each occupied seat skipped on an arrival),
// then a read of the target's entry to report. Synchronous reset clears the
// sequencer, the occupant count and the target register. The receiver cannot
// stall, so each result is shown for exactly one cycle.
`default_nettype none
module lowest_free_seat_allocator_top #(
   parameter int MAX_OCCUPANTS = 256,
   parameter int TIME_BITS     = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_arrival_time,
   input  wire logic [15:0] req_leaving_time,
   input  wire logic        req_last_occupant,
   output logic             rsp_valid,
   output logic [7:0]       rsp_seat,
   output logic             rsp_target_missing,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   localparam int IDXW = $clog2(MAX_OCCUPANTS);
   localparam int CNTW = $clog2(MAX_OCCUPANTS + 1);
   localparam int EVW  = CNTW + 1;
   localparam int KW   = TIME_BITS + 1 + IDXW;
   localparam int SW   = IDXW + 2;            // {seated, taken, seat}
   localparam int SEATED_BIT = IDXW + 1;
   localparam int TAKEN_BIT  = IDXW;

   lsfa_pkg::state_type state_ff, state_in;

   logic [CNTW-1:0] count_ff, count_in;
   logic [CNTW-1:0] scan_ff, scan_in;
   logic [EVW-1:0]  ev_cnt_ff, ev_cnt_in;
   logic [IDXW-1:0] ev_idx_ff, ev_idx_in;
   logic [IDXW-1:0] seat_ff, seat_in;
   logic            rd_valid_ff, rd_valid_in;
   logic [IDXW-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]      target_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_seat_ff, rsp_seat_in;
   logic            rsp_missing_ff, rsp_missing_in;

   logic                   accept;
   logic                   missing;
   logic [31:0]            arr_ext, dep_ext;
   logic [2*TIME_BITS-1:0] tm_wdata, tm_rdata;
   logic                   tm_wen;
   logic [IDXW-1:0]        tm_raddr;
   logic                   st_wen;
   logic [IDXW-1:0]        st_waddr, st_raddr;
   logic [SW-1:0]          st_wdata, st_rdata;
   lsfa_pkg::sel_ctrl_type sel_ctrl;
   logic [KW-1:0]          best_key;
   logic                   best_found;

   assign accept  = start && !busy;
   assign busy    = (state_ff != lsfa_pkg::ST_LOAD);
   assign missing = (32'(target_ff) >= 32'(count_ff));

   // Take the low TIME_BITS of each time field
   assign arr_ext  = 32'(req_arrival_time);
   assign dep_ext  = 32'(req_leaving_time);
   assign tm_wdata = {arr_ext[TIME_BITS-1:0], dep_ext[TIME_BITS-1:0]};
   assign tm_wen   = accept && (count_ff < CNTW'(MAX_OCCUPANTS));
   assign tm_raddr = scan_ff[IDXW-1:0];

   lsfa_ram #(.DEPTH(MAX_OCCUPANTS), .WIDTH(2 * TIME_BITS)) u_time_ram (
      .clock   (clock),
      .wr_en   (tm_wen),
      .wr_addr (count_ff[IDXW-1:0]),
      .wr_data (tm_wdata),
      .rd_addr (tm_raddr),
      .rd_data (tm_rdata)
   );

   lsfa_ram #(.DEPTH(MAX_OCCUPANTS), .WIDTH(SW)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wen),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   lsfa_next_event #(.TIME_BITS(TIME_BITS), .IDX_BITS(IDXW)) u_next_event (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (sel_ctrl),
      .arr_time   (tm_rdata[2*TIME_BITS-1:TIME_BITS]),
      .dep_time   (tm_rdata[TIME_BITS-1:0]),
      .idx        (rd_idx_ff),
      .best_key   (best_key),
      .best_found (best_found)
   );

   // Sequence loading, event scans, seat updates and the report
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      ev_cnt_in      = ev_cnt_ff;
      ev_idx_in      = ev_idx_ff;
      seat_in        = seat_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = scan_ff[IDXW-1:0];
      rsp_valid_in   = 1'b0;
      rsp_seat_in    = rsp_seat_ff;
      rsp_missing_in = rsp_missing_ff;
      st_wen         = 1'b0;
      st_waddr       = seat_ff;
      st_wdata       = st_rdata;
      st_raddr       = seat_ff;
      sel_ctrl       = '0;
      case (state_ff)
         lsfa_pkg::ST_LOAD: begin
            if (tm_wen) begin
               count_in = count_ff + CNTW'(1);
            end
            if (accept && req_last_occupant) begin
               scan_in  = '0;
               state_in = lsfa_pkg::ST_CLEAR;
            end
         end
         lsfa_pkg::ST_CLEAR: begin
            // Wipe seat, taken and seated for every occupant of the set
            st_wen            = 1'b1;
            st_waddr          = scan_ff[IDXW-1:0];
            st_wdata          = '0;
            sel_ctrl.restart    = 1'b1;
            sel_ctrl.scan_start = 1'b1;
            ev_cnt_in         = '0;
            if (scan_ff == count_ff - CNTW'(1)) begin
               scan_in  = '0;
               state_in = lsfa_pkg::ST_SCAN;
            end else begin
               scan_in = scan_ff + CNTW'(1);
            end
         end
         lsfa_pkg::ST_SCAN: begin
            sel_ctrl.sample = rd_valid_ff;
            rd_valid_in     = 1'b1;
            if (scan_ff == count_ff - CNTW'(1)) begin
               state_in = lsfa_pkg::ST_SCAN_WAIT;
            end else begin
               scan_in = scan_ff + CNTW'(1);
            end
         end
         lsfa_pkg::ST_SCAN_WAIT: begin
            sel_ctrl.sample = rd_valid_ff;
            state_in        = lsfa_pkg::ST_EVENT;
         end
         lsfa_pkg::ST_EVENT: begin
            // Decode the chosen event and retire it from the order
            sel_ctrl.commit = 1'b1;
            ev_cnt_in       = ev_cnt_ff + EVW'(1);
            ev_idx_in       = best_key[IDXW-1:0];
            seat_in         = '0;
            if (best_key[IDXW]) begin
               state_in = lsfa_pkg::ST_ARR_RD;
            end else begin
               state_in = lsfa_pkg::ST_DEP_RD;
            end
         end
         lsfa_pkg::ST_DEP_RD: begin
            st_raddr = ev_idx_ff;
            state_in = lsfa_pkg::ST_DEP_WR;
         end
         lsfa_pkg::ST_DEP_WR: begin
            // Drop the seated mark, remember the seat to release
            if (st_rdata[SEATED_BIT]) begin
               st_wen   = 1'b1;
               st_waddr = ev_idx_ff;
               st_wdata = st_rdata;
               st_wdata[SEATED_BIT] = 1'b0;
               seat_in  = st_rdata[IDXW-1:0];
               state_in = lsfa_pkg::ST_DEP_RD2;
            end else begin
               state_in = lsfa_pkg::ST_NEXT;
            end
         end
         lsfa_pkg::ST_DEP_RD2: begin
            st_raddr = seat_ff;
            state_in = lsfa_pkg::ST_DEP_WR2;
         end
         lsfa_pkg::ST_DEP_WR2: begin
            st_wen   = 1'b1;
            st_waddr = seat_ff;
            st_wdata = st_rdata;
            st_wdata[TAKEN_BIT] = 1'b0;
            state_in = lsfa_pkg::ST_NEXT;
         end
         lsfa_pkg::ST_ARR_RD: begin
            st_raddr = seat_ff;
            state_in = lsfa_pkg::ST_ARR_CHK;
         end
         lsfa_pkg::ST_ARR_CHK: begin
            // Claim the first free seat, else advance to the next one
            if (!st_rdata[TAKEN_BIT]) begin
               st_wen   = 1'b1;
               st_waddr = seat_ff;
               st_wdata = st_rdata;
               st_wdata[TAKEN_BIT] = 1'b1;
               state_in = lsfa_pkg::ST_ARR_RD2;
            end else begin
               seat_in  = seat_ff + IDXW'(1);
               state_in = lsfa_pkg::ST_ARR_RD;
            end
         end
         lsfa_pkg::ST_ARR_RD2: begin
            st_raddr = ev_idx_ff;
            state_in = lsfa_pkg::ST_ARR_WR2;
         end
         lsfa_pkg::ST_ARR_WR2: begin
            st_wen   = 1'b1;
            st_waddr = ev_idx_ff;
            st_wdata = {1'b1, st_rdata[TAKEN_BIT], seat_ff};
            state_in = lsfa_pkg::ST_NEXT;
         end
         lsfa_pkg::ST_NEXT: begin
            sel_ctrl.scan_start = 1'b1;
            scan_in = '0;
            if (ev_cnt_ff == {count_ff, 1'b0}) begin
               state_in = lsfa_pkg::ST_RPT_RD;
            end else begin
               state_in = lsfa_pkg::ST_SCAN;
            end
         end
         lsfa_pkg::ST_RPT_RD: begin
            st_raddr = IDXW'(target_ff);
            state_in = lsfa_pkg::ST_RPT_OUT;
         end
         lsfa_pkg::ST_RPT_OUT: begin
            rsp_valid_in   = 1'b1;
            rsp_missing_in = missing;
            rsp_seat_in    = missing ? 8'd0 : 8'(st_rdata[IDXW-1:0]);
            count_in       = '0;
            state_in       = lsfa_pkg::ST_LOAD;
         end
         default: begin
            state_in = lsfa_pkg::ST_LOAD;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsfa_pkg::ST_LOAD;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

   // Advance counters and payload
   always_ff @(posedge clock) begin
      scan_ff        <= scan_in;
      ev_cnt_ff      <= ev_cnt_in;
      ev_idx_ff      <= ev_idx_in;
      seat_ff        <= seat_in;
      rd_idx_ff      <= rd_idx_in;
      rsp_seat_ff    <= rsp_seat_in;
      rsp_missing_ff <= rsp_missing_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_seat           = rsp_seat_ff;
   assign rsp_target_missing = rsp_missing_ff;

   // A missing target always reports seat zero
   a_missing_seat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_target_missing) |-> (rsp_seat == 8'd0))
      else $error("missing target reported a nonzero seat");

   // Leaving busy always comes with a result
   a_busy_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // The seat search never runs past the occupant count
   a_seat_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsfa_pkg::ST_ARR_CHK) |-> (CNTW'(seat_ff) < count_ff))
      else $error("seat search overran the set");

   // Every event commit follows a scan that found a candidate
   a_event_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsfa_pkg::ST_EVENT) |-> best_found)
      else $error("event taken without a candidate");

endmodule
`default_nettype wire
